@@ hw/rtl/scfp_pkg.sv @@
// Shared constants and helpers for the serial command frame parser.
// Frame marker bytes, frame type codes, payload geometry and the servo scaling.
// No dependencies.
package scfp_pkg;

    localparam logic [7:0] HDR_A        = 8'hFA;
    localparam logic [7:0] HDR_B        = 8'hAF;
    localparam logic [7:0] TAIL_A       = 8'hFB;
    localparam logic [7:0] TAIL_B       = 8'hBF;
    localparam logic [7:0] TYPE_STATUS  = 8'h52;
    localparam logic [7:0] TYPE_COMMAND = 8'h49;

    localparam int PAYLOAD_LEN = 17;
    localparam int COUNT_W     = 5;
    localparam int ANGLE_IDX   = 16;

    localparam logic [0:0] KIND_STATUS  = 1'b0;
    localparam logic [0:0] KIND_COMMAND = 1'b1;

    localparam logic [COUNT_W-1:0] PAYLOAD_LAST = COUNT_W'(PAYLOAD_LEN - 1);
    localparam logic [COUNT_W-1:0] PAYLOAD_CNT  = COUNT_W'(PAYLOAD_LEN);

    localparam logic [7:0] SERVO_MIN = 8'd50;
    localparam logic [7:0] SERVO_MAX = 8'd249;

    // Rounded 50 + angle*200/256, done as (angle*25 + 1616) >> 5.
    function automatic logic [7:0] servo_from_angle(input logic [7:0] ang);
        logic [12:0] acc;
        acc = {5'd0, ang} * 13'd25 + 13'd1616;
        return acc[12:5];
    endfunction

endpackage

@@ hw/rtl/serial_command_frame_parser.sv @@
// Serial command frame parser top level: header/type/payload/checksum/tail tracking
// and the registered result word.
// Depends on scfp_pkg.
//
// Usage
//   Input channel: one received byte per word on rx_byte, handshake in_valid/in_ready.
//   Output channel: one word per complete frame, handshake out_valid/out_ready.
//   Frames: FA AF 52 FB BF (status request) or
//           FA AF 49 <17 payload bytes> <xor of type+payload> FB BF (command).
//   A byte that does not match drops the parser back to hunting for FA; that byte
//   is discarded, not rechecked as a header.
// Pipeline and throughput
//   A byte is registered on acceptance and parsed in the following cycle; out_valid
//   is registered from the parsed final BF byte. One byte per cycle is sustained
//   unless in_ready drops; only the input register lies ahead of the result register.
// Stall behavior
//   in_ready drops only when the held byte completes a frame while the previous
//   result is still waiting and out_ready is low; other bytes keep flowing.
// Reset
//   rst_n clears phase, checksum, count and valid flags; payload store is kept as is.
module serial_command_frame_parser
    import scfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_kind,
    output logic [31:0] y_word,
    output logic [31:0] x_word,
    output logic [31:0] z_word,
    output logic [31:0] yaw_word,
    output logic [7:0]  angle_byte,
    output logic [7:0]  servo_compare
);

    typedef enum logic [2:0] {
        PH_HDR_A,
        PH_HDR_B,
        PH_TYPE,
        PH_DATA,
        PH_CSUM,
        PH_TAIL_A,
        PH_TAIL_B
    } phase_t;

    // input register
    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_reg;

    // parse state
    phase_t             phase_reg, phase_next;
    logic               type_reg, type_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         xor_reg, xor_next;

    logic [7:0] payload_mem [PAYLOAD_LEN];
    logic       wr_en;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] z_reg, z_next;
    logic [31:0] yaw_reg, yaw_next;
    logic [7:0]  angle_reg, angle_next;
    logic [7:0]  servo_reg, servo_next;

    logic hit_result;
    logic advance;
    logic step;

    // A frame completes when the held byte is the final tail byte in the last phase.
    assign hit_result = byte_valid_reg && (phase_reg == PH_TAIL_B) && (byte_reg == TAIL_B);
    // The parse stage only blocks when it must deliver into an occupied result slot.
    assign advance    = !hit_result || !out_valid_reg || out_ready;
    assign step       = byte_valid_reg && advance;
    assign in_ready   = advance;

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        wr_en      = 1'b0;

        if (step)
        begin
            case (phase_reg)
                PH_HDR_A:
                begin
                    if (byte_reg == HDR_A)
                        phase_next = PH_HDR_B;
                end
                PH_HDR_B:
                begin
                    phase_next = (byte_reg == HDR_B) ? PH_TYPE : PH_HDR_A;
                end
                PH_TYPE:
                begin
                    if (byte_reg == TYPE_STATUS)
                    begin
                        type_next  = KIND_STATUS;
                        phase_next = PH_TAIL_A;
                    end
                    else if (byte_reg == TYPE_COMMAND)
                    begin
                        type_next  = KIND_COMMAND;
                        count_next = '0;
                        xor_next   = byte_reg;
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_HDR_A;
                    end
                end
                PH_DATA:
                begin
                    if (count_reg < PAYLOAD_CNT)
                    begin
                        wr_en      = 1'b1;
                        xor_next   = xor_reg ^ byte_reg;
                        count_next = count_reg + 1'b1;
                        if (count_reg == PAYLOAD_LAST)
                            phase_next = PH_CSUM;
                    end
                    else
                    begin
                        // count overrun: skip straight to the checksum
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                    phase_next = (byte_reg == xor_reg) ? PH_TAIL_A : PH_HDR_A;
                end
                PH_TAIL_A:
                begin
                    phase_next = (byte_reg == TAIL_A) ? PH_TAIL_B : PH_HDR_A;
                end
                PH_TAIL_B:
                begin
                    phase_next = PH_HDR_A;
                end
                default:
                begin
                    phase_next = PH_HDR_A;
                end
            endcase
        end
    end

    // Result word assembly; status frames carry zeros in every payload field.
    always_comb
    begin
        kind_next  = kind_reg;
        y_next     = y_reg;
        x_next     = x_reg;
        z_next     = z_reg;
        yaw_next   = yaw_reg;
        angle_next = angle_reg;
        servo_next = servo_reg;

        if (hit_result && advance)
        begin
            kind_next = type_reg;
            if (type_reg == KIND_COMMAND)
            begin
                y_next     = {payload_mem[3],  payload_mem[2],  payload_mem[1],  payload_mem[0]};
                x_next     = {payload_mem[7],  payload_mem[6],  payload_mem[5],  payload_mem[4]};
                z_next     = {payload_mem[11], payload_mem[10], payload_mem[9],  payload_mem[8]};
                yaw_next   = {payload_mem[15], payload_mem[14], payload_mem[13], payload_mem[12]};
                angle_next = payload_mem[ANGLE_IDX];
                servo_next = servo_from_angle(payload_mem[ANGLE_IDX]);
            end
            else
            begin
                y_next     = '0;
                x_next     = '0;
                z_next     = '0;
                yaw_next   = '0;
                angle_next = '0;
                servo_next = '0;
            end
        end
    end

    always_comb
    begin
        if (hit_result && advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        if (in_valid && in_ready)
            byte_valid_next = 1'b1;
        else if (step)
            byte_valid_next = 1'b0;
        else
            byte_valid_next = byte_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            phase_reg      <= PH_HDR_A;
            type_reg       <= 1'b0;
            count_reg      <= '0;
            xor_reg        <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= 1'b0;
            y_reg          <= '0;
            x_reg          <= '0;
            z_reg          <= '0;
            yaw_reg        <= '0;
            angle_reg      <= '0;
            servo_reg      <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            phase_reg      <= phase_next;
            type_reg       <= type_next;
            count_reg      <= count_next;
            xor_reg        <= xor_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            y_reg          <= y_next;
            x_reg          <= x_next;
            z_reg          <= z_next;
            yaw_reg        <= yaw_next;
            angle_reg      <= angle_next;
            servo_reg      <= servo_next;
        end
    end

    // Input byte and payload store carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= rx_byte;
        if (wr_en)
            payload_mem[count_reg] <= byte_reg;
    end

    assign out_valid     = out_valid_reg;
    assign frame_kind    = kind_reg;
    assign y_word        = y_reg;
    assign x_word        = x_reg;
    assign z_word        = z_reg;
    assign yaw_word      = yaw_reg;
    assign angle_byte    = angle_reg;
    assign servo_compare = servo_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Payload count never runs past the payload length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PAYLOAD_CNT)
        else $error("payload count overran");

    // A completed frame always lands in the result register next cycle.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_result && advance) |=> out_valid_reg)
        else $error("completed frame not delivered");

    // Status results carry zeros in all payload fields.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_STATUS)) |->
        (y_reg == '0 && x_reg == '0 && z_reg == '0 && yaw_reg == '0 &&
         angle_reg == '0 && servo_reg == '0))
        else $error("status result with nonzero payload");

    // Command results keep the servo value inside its timer range.
    a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_COMMAND)) |->
        (servo_reg >= SERVO_MIN && servo_reg <= SERVO_MAX))
        else $error("servo compare out of range");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for serial_command_frame_parser: directed and random byte
// streams, a byte-level frame predictor and an in-order result check.
// Depends on scfp_pkg and the serial_command_frame_parser RTL.
module tb_top
    import scfp_pkg::*;
();

    // One parsed frame as it leaves the block.
    typedef struct packed {
        logic        kind;
        logic [31:0] y;
        logic [31:0] x;
        logic [31:0] z;
        logic [31:0] yaw;
        logic [7:0]  angle;
        logic [7:0]  servo;
    } frame_result_t;

    typedef logic [7:0] byte_q_t [$];

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_e;

    // Tracks the parser byte by byte and holds the frames it should emit, oldest first.
    class frame_checker;
        typedef enum logic [2:0] {
            PH_HUNT_A, PH_HUNT_B, PH_TYPE, PH_DATA, PH_CSUM, PH_TAIL_A, PH_TAIL_B
        } phase_e;

        phase_e          phase;
        logic            kind;
        logic [4:0]      count;
        logic [7:0]      xsum;
        logic [7:0]      payload [PAYLOAD_LEN];
        frame_result_t   pending_frames [$];
        int              mismatches;

        function new();
            phase      = PH_HUNT_A;
            kind       = KIND_STATUS;
            count      = '0;
            xsum       = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_frames.size();
        endfunction

        // Advance the parse state by one accepted byte.
        function void note_byte(input logic [7:0] b);
            frame_result_t r;
            logic [12:0]   acc;
            case (phase)
                PH_HUNT_A: if (b == HDR_A) phase = PH_HUNT_B;
                PH_HUNT_B: phase = (b == HDR_B) ? PH_TYPE : PH_HUNT_A;
                PH_TYPE:
                begin
                    if (b == TYPE_STATUS)
                    begin
                        kind  = KIND_STATUS;
                        phase = PH_TAIL_A;
                    end
                    else if (b == TYPE_COMMAND)
                    begin
                        kind  = KIND_COMMAND;
                        count = '0;
                        xsum  = b;
                        phase = PH_DATA;
                    end
                    else
                        phase = PH_HUNT_A;
                end
                PH_DATA:
                begin
                    payload[count] = b;
                    xsum  = xsum ^ b;
                    count = count + 5'd1;
                    if (count == PAYLOAD_CNT) phase = PH_CSUM;
                end
                PH_CSUM:   phase = (b == xsum) ? PH_TAIL_A : PH_HUNT_A;
                PH_TAIL_A: phase = (b == TAIL_A) ? PH_TAIL_B : PH_HUNT_A;
                PH_TAIL_B:
                begin
                    if (b == TAIL_B)
                    begin
                        r      = '0;
                        r.kind = kind;
                        if (kind == KIND_COMMAND)
                        begin
                            r.y     = {payload[3], payload[2], payload[1], payload[0]};
                            r.x     = {payload[7], payload[6], payload[5], payload[4]};
                            r.z     = {payload[11], payload[10], payload[9], payload[8]};
                            r.yaw   = {payload[15], payload[14], payload[13], payload[12]};
                            r.angle = payload[ANGLE_IDX];
                            acc     = {5'd0, r.angle} * 13'd25 + 13'd1616;
                            r.servo = acc[12:5];
                        end
                        pending_frames.push_back(r);
                    end
                    phase = PH_HUNT_A;
                end
                default:   phase = PH_HUNT_A;
            endcase
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input frame_result_t got);
            frame_result_t want;
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected frame, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = pending_frames.pop_front();
            compare_field("frame_kind", 32'(want.kind), 32'(got.kind));
            compare_field("y_word", want.y, got.y);
            compare_field("x_word", want.x, got.x);
            compare_field("z_word", want.z, got.z);
            compare_field("yaw_word", want.yaw, got.yaw);
            compare_field("angle_byte", 32'(want.angle), 32'(got.angle));
            compare_field("servo_compare", 32'(want.servo), 32'(got.servo));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        frame_kind;
    logic [31:0] y_word;
    logic [31:0] x_word;
    logic [31:0] z_word;
    logic [31:0] yaw_word;
    logic [7:0]  angle_byte;
    logic [7:0]  servo_compare;

    frame_checker chk = new();

    // Idle odds in percent per cycle; the stimulus process sets them per stage.
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    // Raised by the stimulus to make the sink hold off for a long stretch.
    bit hold_request = 1'b0;

    serial_command_frame_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_kind    (frame_kind),
        .y_word        (y_word),
        .x_word        (x_word),
        .z_word        (z_word),
        .yaw_word      (yaw_word),
        .angle_byte    (angle_byte),
        .servo_compare (servo_compare)
    );

    always #6 clk = ~clk;

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(12 * 400000);
        $display("serial_command_frame_parser verification failed");
        $finish;
    end

    // Offer one word. in_valid is lowered only while idling, so back-to-back
    // words never see a low and a high scheduled in the same step. The handshake
    // is judged on the values seen at the edge, before this edge's updates land.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99, 0) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        chk.note_byte(b);
    endtask

    task automatic send_bytes(input byte_q_t f);
        foreach (f[i]) send_byte(f[i]);
    endtask

    function automatic byte_q_t status_frame();
        return '{HDR_A, HDR_B, TYPE_STATUS, TAIL_A, TAIL_B};
    endfunction

    // Well-formed command frame; checksum folds the type byte and all payload bytes.
    function automatic byte_q_t command_frame(input fill_e fill);
        byte_q_t    f;
        logic [7:0] b;
        logic [7:0] csum;
        f    = '{HDR_A, HDR_B, TYPE_COMMAND};
        csum = TYPE_COMMAND;
        for (int i = 0; i < PAYLOAD_LEN; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            f.push_back(b);
            csum = csum ^ b;
        end
        f.push_back(csum);
        f.push_back(TAIL_A);
        f.push_back(TAIL_B);
        return f;
    endfunction

    function automatic byte_q_t random_frame();
        int    pick;
        fill_e fill;
        pick = $urandom_range(7, 0);
        fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
        if ($urandom_range(99, 0) < 25) return status_frame();
        return command_frame(fill);
    endfunction

    // Random mix: mostly good frames, some corrupted or cut short, some line noise.
    // Returns once about 'target' frame bytes went out; noise is not counted.
    task automatic run_stage(input int snd_pct, input int rcv_pct, input int target);
        byte_q_t f;
        int      sent;
        int      pick;
        int      idx;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 12)
            begin
                // noise burst, header bytes now and then so hunting gets exercised
                f = {};
                repeat ($urandom_range(6, 1))
                    f.push_back(($urandom_range(3, 0) == 0) ? HDR_A : 8'($urandom));
                send_bytes(f);
            end
            else
            begin
                f = random_frame();
                if (pick < 22)
                begin
                    // flip some bits of one byte: header, type, payload, checksum or tail
                    idx    = $urandom_range(f.size() - 1, 0);
                    f[idx] = f[idx] ^ 8'($urandom_range(255, 1));
                end
                else if (pick < 27)
                    // truncated: the next frame's bytes land mid-parse
                    f = f[0:$urandom_range(f.size() - 2, 0)];
                send_bytes(f);
                sent += f.size();
            end
        end
    endtask

    // Result sink. A result is taken on the outputs seen at the edge; out_ready
    // for the next cycle gets exactly one assignment per edge.
    initial
    begin : result_sink
        int            hold_left;
        frame_result_t got;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.kind  = frame_kind;
                got.y     = y_word;
                got.x     = x_word;
                got.z     = z_word;
                got.yaw   = yaw_word;
                got.angle = angle_byte;
                got.servo = servo_compare;
                chk.check_result(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                // long hold-off: the parser fills and must drop in_ready
                hold_request = 1'b0;
                hold_left    = 300;
                out_ready    <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
        end
    end

    initial
    begin : stimulus
        byte_q_t f;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: status frame, command with every payload bit set (angle at max).
        send_bytes(status_frame());
        send_bytes(command_frame(FILL_ONES));
        // status frame with a bad final tail byte: no frame
        send_bytes('{HDR_A, HDR_B, TYPE_STATUS, TAIL_A, 8'h00});
        // unknown type byte
        send_bytes('{HDR_A, HDR_B, 8'h00});
        // a failing header byte is dropped, not taken as a fresh header
        send_bytes('{HDR_A, HDR_A, HDR_B, TYPE_STATUS, TAIL_A, TAIL_B});

        // Random part in three idle regimes; the last one also holds the sink off.
        run_stage(6, 69, 430);
        run_stage(69, 6, 430);
        hold_request = 1'b1;
        run_stage(0, 0, 430);
        in_valid <= 1'b0;

        while (chk.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (chk.mismatches == 0 && chk.pending() == 0)
            $display("serial_command_frame_parser verification clean");
        else
            $display("serial_command_frame_parser verification failed");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/scfp_pkg.sv
hw/rtl/serial_command_frame_parser.sv
dv/tb_top.sv
